### rtl/core/size_budget_lru_cache_policy_top_assert.svh
// Assertion macros used by the block's back end.
`ifndef SIZE_BUDGET_LRU_CACHE_POLICY_TOP_ASSERT_SVH
`define SIZE_BUDGET_LRU_CACHE_POLICY_TOP_ASSERT_SVH

// Property that an implication holds on every clock edge outside reset.
`define SBL_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Property that a condition holds on every clock edge outside reset.
`define SBL_ASSERT_ALW(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

### rtl/core/sblru_pkg.sv
// ----------------------------------------------------------------------------
// sblru_pkg
// Types, codes and constants of the size-budget LRU residency manager.
// ----------------------------------------------------------------------------
package sblru_pkg;

  localparam int unsigned DEF_SLOT_COUNT = 32;
  localparam logic [31:0] LIMIT_RESET    = 32'd16777216;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_ACCESS = 2'd2,
    KIND_TRIM   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    RES_DONE     = 3'd0,
    RES_EVICTED  = 3'd1,
    RES_FILL     = 3'd2,
    RES_NOVICTIM = 3'd3,
    RES_BADSLOT  = 3'd4
  } res_kind_t;

  // Transaction handed from the front end to the back end.
  typedef struct packed {
    kind_t       kind;
    logic [4:0]  slot;
    logic [23:0] entry_size;
    logic [31:0] member_id;
    logic        option_flag;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    res_kind_t   result_kind;
    logic [4:0]  slot_res;
    logic [31:0] member_id_out;
    logic        restore;
    logic [31:0] used_size;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_EVICT,
    ST_FINISH
  } state_t;

endpackage

### rtl/core/size_budget_lru_cache_policy_top.sv
// ----------------------------------------------------------------------------
// size_budget_lru_cache_policy_top
// LRU residency manager for variable-size entries under a byte budget.
// ----------------------------------------------------------------------------
// One transaction at a time is executed. Add, remove, a hit and a trim that
// already fits end in the decide step. Every eviction costs one scan of the
// slot table, one slot a cycle, then an evict step.
// Results leave through a one-deep output register; a two-deep command queue
// and an input holding register let new transactions arrive while one runs.
// capacity_limit sits at byte address 0 of the APB port.
module size_budget_lru_cache_policy_top
  import sblru_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [4:0]  slot,
  input  logic [23:0] entry_size,
  input  logic [31:0] member_id,
  input  logic        option_flag,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  result_kind,
  output logic [4:0]  slot_res,
  output logic [31:0] member_id_out,
  output logic        restore,
  output logic [31:0] used_size,
  output logic        last
);

  logic [31:0] capacity_limit;
  logic        q_wr, q_full, q_empty, q_rd;
  cmd_t        q_in, q_out;
  res_t        res;

  // Single register at address 0; reads of address 1 return zero.
  assign pready = 1'b1;
  assign prdata = paddr ? 32'd0 : capacity_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && !paddr) begin
      capacity_limit <= pwdata;
    end
  end

  sblru_front u_front (
    .clk, .rst, .push, .full, .kind, .slot, .entry_size, .member_id, .option_flag,
    .q_wr, .q_data(q_in), .q_full
  );

  sblru_cmd_fifo u_fifo (
    .clk, .rst, .wr_en(q_wr), .wr_data(q_in), .full(q_full),
    .rd_en(q_rd), .rd_data(q_out), .empty(q_empty)
  );

  sblru_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
    .clk, .rst, .capacity_limit, .cmd(q_out), .cmd_valid(!q_empty),
    .cmd_take(q_rd), .empty, .pop, .res
  );

  assign result_kind   = res.result_kind;
  assign slot_res      = res.slot_res;
  assign member_id_out = res.member_id_out;
  assign restore       = res.restore;
  assign used_size     = res.used_size;
  assign last          = res.last;

endmodule

### rtl/core/sblru_cmd_fifo.sv
// ----------------------------------------------------------------------------
// sblru_cmd_fifo
// Short command queue between the front end and the execution back end.
// ----------------------------------------------------------------------------
module sblru_cmd_fifo
  import sblru_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en && !full) wr_ptr <= ~wr_ptr;
      if (rd_en && !empty) rd_ptr <= ~rd_ptr;
      count <= count + 2'(wr_en && !full) - 2'(rd_en && !empty);
    end
  end

endmodule

### rtl/core/sblru_front.sv
// ----------------------------------------------------------------------------
// sblru_front
// Input side: takes transactions and tags each with its decoded kind.
// ----------------------------------------------------------------------------
module sblru_front
  import sblru_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [4:0]  slot,
  input  logic [23:0] entry_size,
  input  logic [31:0] member_id,
  input  logic        option_flag,
  output logic        q_wr,
  output cmd_t        q_data,
  input  logic        q_full
);

  // One-entry holding register in front of the queue.
  logic held;
  cmd_t held_cmd;

  assign full   = held;
  assign q_wr   = held;
  assign q_data = held_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (push && !held) begin
      held <= 1'b1;
    end else if (held && !q_full) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !held) begin
      held_cmd.kind        <= kind_t'(kind);
      held_cmd.slot        <= slot;
      held_cmd.entry_size  <= entry_size;
      held_cmd.member_id   <= member_id;
      held_cmd.option_flag <= option_flag;
    end
  end

endmodule

### rtl/core/sblru_back.sv
// ----------------------------------------------------------------------------
// sblru_back
// Execution engine: slot table, budget accounting and victim scan.
// ----------------------------------------------------------------------------
module sblru_back
  import sblru_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] capacity_limit,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_take,
  output logic        empty,
  input  logic        pop,
  output res_t        res
);

  localparam int IW = $clog2(SLOT_COUNT);

  logic [SLOT_COUNT-1:0] valid_q, resident_q;
  logic [SLOT_COUNT-1:0] pinned_q;
  logic [23:0]           size_q  [SLOT_COUNT];
  logic [31:0]           ident_q [SLOT_COUNT];
  logic [31:0]           stamp_q [SLOT_COUNT];
  logic [31:0]           bytes_used;
  logic [31:0]           stamp_ctr;

  state_t       state, state_next;
  cmd_t         cur;
  logic [IW:0]  scan_idx;
  logic         best_ok;
  logic [IW-1:0] best_idx;
  logic [31:0]  best_stamp;

  // Output register: one result held until popped.
  logic out_full;

  assign empty = !out_full;

  logic        slot_ok;
  logic [IW-1:0] si;
  logic [32:0] need;
  logic        fits;
  logic [IW-1:0] sc;
  logic        cand;
  logic        advance;
  logic        needs_scan;
  logic        scan_done;
  logic        res_load;

  assign slot_ok = ({1'b0, cur.slot} < 6'(SLOT_COUNT));
  assign si      = IW'(cur.slot);
  assign need    = (cur.kind == KIND_TRIM) ? 33'd0 : {9'd0, size_q[si]};
  assign fits    = ({1'b0, bytes_used} + need) <= {1'b0, capacity_limit};
  assign sc      = scan_idx[IW-1:0];
  assign cand    = valid_q[sc] && resident_q[sc] && !pinned_q[sc];

  // Output register free, or being emptied this cycle.
  assign advance    = !out_full || pop;
  // Trim, or an access miss on a valid slot, that does not fit yet.
  assign needs_scan = !fits && ((cur.kind == KIND_TRIM) ||
                      (cur.kind == KIND_ACCESS && slot_ok && valid_q[si] &&
                       !resident_q[si]));
  assign scan_done  = (scan_idx == (IW+1)'(SLOT_COUNT - 1));

  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    res_load   = 1'b0;
    case (state)
      ST_IDLE: if (cmd_valid) begin
        state_next = ST_DECIDE;
        cmd_take   = 1'b1;
      end
      ST_DECIDE: if (advance) begin
        state_next = needs_scan ? ST_SCAN : ST_IDLE;
        res_load   = !needs_scan;
      end
      ST_SCAN: if (scan_done) state_next = ST_EVICT;
      ST_EVICT: if (advance) begin
        state_next = best_ok ? ST_DECIDE : ST_IDLE;
        res_load   = 1'b1;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  task automatic put(input res_kind_t k, input logic [4:0] s, input logic [31:0] id,
                     input logic rs, input logic [31:0] used, input logic lst);
    res.result_kind   <= k;
    res.slot_res      <= s;
    res.member_id_out <= id;
    res.restore       <= rs;
    res.used_size     <= used;
    res.last          <= lst;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_full   <= 1'b0;
      valid_q    <= '0;
      resident_q <= '0;
      bytes_used <= '0;
      stamp_ctr  <= '0;
      scan_idx   <= '0;
      best_ok    <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) out_full <= 1'b1;
      else if (pop && out_full) out_full <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
          end
        end
        ST_DECIDE: begin
          if (advance) begin
            if (cur.kind != KIND_TRIM && !slot_ok) begin
              put(RES_BADSLOT, cur.slot, '0, 1'b0, bytes_used, 1'b1);
            end else if (cur.kind == KIND_ADD) begin
              if (valid_q[si]) begin
                put(RES_BADSLOT, cur.slot, ident_q[si], 1'b0, bytes_used, 1'b1);
              end else begin
                valid_q[si]    <= 1'b1;
                pinned_q[si]   <= cur.option_flag;
                resident_q[si] <= cur.option_flag;
                size_q[si]     <= cur.entry_size;
                ident_q[si]    <= cur.member_id;
                stamp_q[si]    <= '0;
                put(RES_DONE, cur.slot, cur.member_id, 1'b0, bytes_used, 1'b1);
              end
            end else if (cur.kind != KIND_TRIM && !valid_q[si]) begin
              put(RES_BADSLOT, cur.slot, '0, 1'b0, bytes_used, 1'b1);
            end else if (cur.kind == KIND_REMOVE) begin
              valid_q[si]    <= 1'b0;
              resident_q[si] <= 1'b0;
              if (resident_q[si] && !pinned_q[si]) begin
                bytes_used <= bytes_used - 32'(size_q[si]);
                put(RES_DONE, cur.slot, ident_q[si], 1'b0,
                    bytes_used - 32'(size_q[si]), 1'b1);
              end else begin
                put(RES_DONE, cur.slot, ident_q[si], 1'b0, bytes_used, 1'b1);
              end
            end else if (cur.kind == KIND_ACCESS && resident_q[si]) begin
              stamp_q[si] <= stamp_ctr;
              stamp_ctr   <= stamp_ctr + 32'd1;
              put(RES_DONE, cur.slot, ident_q[si], 1'b0, bytes_used, 1'b1);
            end else if (fits) begin
              if (cur.kind == KIND_TRIM) begin
                put(RES_DONE, 5'd0, '0, 1'b0, bytes_used, 1'b1);
              end else begin
                resident_q[si] <= 1'b1;
                stamp_q[si]    <= stamp_ctr;
                stamp_ctr      <= stamp_ctr + 32'd1;
                bytes_used     <= bytes_used + 32'(size_q[si]);
                put(RES_FILL, cur.slot, ident_q[si], !cur.option_flag,
                    bytes_used + 32'(size_q[si]), 1'b1);
              end
            end else begin
              // Need room: scan the table for the oldest unpinned resident.
              scan_idx <= '0;
              best_ok  <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (cand && (!best_ok || stamp_q[sc] < best_stamp)) begin
            best_ok    <= 1'b1;
            best_idx   <= sc;
            best_stamp <= stamp_q[sc];
          end
          if (!scan_done) scan_idx <= scan_idx + (IW+1)'(1);
        end
        ST_EVICT: begin
          if (advance) begin
            if (best_ok) begin
              resident_q[best_idx] <= 1'b0;
              bytes_used <= bytes_used - 32'(size_q[best_idx]);
              put(RES_EVICTED, 5'(best_idx), ident_q[best_idx], 1'b0,
                  bytes_used - 32'(size_q[best_idx]), 1'b0);
            end else if (cur.kind == KIND_TRIM) begin
              put(RES_NOVICTIM, 5'd0, '0, 1'b0, bytes_used, 1'b1);
            end else begin
              put(RES_NOVICTIM, cur.slot, ident_q[si], 1'b0, bytes_used, 1'b1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  `include "size_budget_lru_cache_policy_top_assert.svh"
  `SBL_ASSERT_IMP(a_take_idle, clk, rst, cmd_take, state == ST_IDLE, "take outside idle")
  `SBL_ASSERT_IMP(a_evict_found, clk, rst, out_full && res.result_kind == RES_EVICTED, !res.last, "evict marked last")
  `SBL_ASSERT_IMP(a_scan_range, clk, rst, state == ST_SCAN, scan_idx < (IW+1)'(SLOT_COUNT), "scan overrun")

endmodule

### tb/size_budget_lru_cache_policy_top_tb.sv
// ----------------------------------------------------------------------------
// size_budget_lru_cache_policy_top_tb
// Self-checking bench for the size-budget LRU residency manager: a scoreboard
// predicts every result transaction from the accepted commands and checks the
// popped results in order, over several budget settings and idling phases.
// ----------------------------------------------------------------------------
module size_budget_lru_cache_policy_top_tb;
  import sblru_pkg::*;

  localparam int NSLOT    = DEF_SLOT_COUNT;
  localparam int WDOG_MAX = 40000;

  // Residency predictor plus the store of expected result transactions.
  class lru_scoreboard;
    logic [31:0] limit;
    bit          valid[NSLOT];
    bit          resident[NSLOT];
    bit          pinned[NSLOT];
    logic [23:0] size[NSLOT];
    logic [31:0] ident[NSLOT];
    logic [31:0] stamp[NSLOT];
    logic [31:0] charged;
    logic [31:0] stamp_ctr;
    res_t        pending[$];
    int          errors;

    function new();
      limit = LIMIT_RESET;
      foreach (valid[i]) begin
        valid[i] = 0;
        resident[i] = 0;
      end
      charged = 0;
      stamp_ctr = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void push_res(res_kind_t k, int s, logic [31:0] id, bit rs, bit lst);
      res_t r;
      r.result_kind = k;
      r.slot_res = s[4:0];
      r.member_id_out = id;
      r.restore = rs;
      r.used_size = charged;
      r.last = lst;
      pending.push_back(r);
    endfunction

    function int oldest_slot();
      int best;
      best = -1;
      for (int i = 0; i < NSLOT; i++)
        if (valid[i] && resident[i] && !pinned[i])
          if (best < 0 || stamp[i] < stamp[best]) best = i;
      return best;
    endfunction

    // Evicts until need fits the budget; 0 when nothing is left to evict.
    function bit evict_until_fits(logic [32:0] need);
      int v;
      while ({1'b0, charged} + need > {1'b0, limit}) begin
        v = oldest_slot();
        if (v < 0) return 0;
        resident[v] = 0;
        charged = charged - {8'd0, size[v]};
        push_res(RES_EVICTED, v, ident[v], 0, 0);
      end
      return 1;
    endfunction

    function void note_command(kind_t k, int s, logic [23:0] sz, logic [31:0] id,
                               bit flag);
      case (k)
        KIND_TRIM: begin
          if (!evict_until_fits(0)) push_res(RES_NOVICTIM, 0, 0, 0, 1);
          else push_res(RES_DONE, 0, 0, 0, 1);
        end
        KIND_ADD: begin
          if (valid[s]) begin
            push_res(RES_BADSLOT, s, ident[s], 0, 1);
          end else begin
            valid[s] = 1;
            pinned[s] = flag;
            resident[s] = flag;
            size[s] = sz;
            ident[s] = id;
            stamp[s] = 0;
            push_res(RES_DONE, s, id, 0, 1);
          end
        end
        default: begin
          if (!valid[s]) begin
            push_res(RES_BADSLOT, s, 0, 0, 1);
          end else if (k == KIND_REMOVE) begin
            if (resident[s] && !pinned[s]) charged = charged - {8'd0, size[s]};
            valid[s] = 0;
            resident[s] = 0;
            push_res(RES_DONE, s, ident[s], 0, 1);
          end else if (resident[s]) begin
            stamp[s] = stamp_ctr;
            stamp_ctr++;
            push_res(RES_DONE, s, ident[s], 0, 1);
          end else if (!evict_until_fits({9'd0, size[s]})) begin
            push_res(RES_NOVICTIM, s, ident[s], 0, 1);
          end else begin
            resident[s] = 1;
            stamp[s] = stamp_ctr;
            stamp_ctr++;
            charged = charged + {8'd0, size[s]};
            push_res(RES_FILL, s, ident[s], !flag, 1);
          end
        end
      endcase
    endfunction

    task check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result kind %0d slot %0d",
                         got.result_kind, got.slot_res));
        return;
      end
      want = pending.pop_front();
      if (got.result_kind !== want.result_kind)
        report($sformatf("result_kind %0d, want %0d", got.result_kind, want.result_kind));
      if (got.slot_res !== want.slot_res)
        report($sformatf("slot_res %0d, want %0d", got.slot_res, want.slot_res));
      if (got.member_id_out !== want.member_id_out)
        report($sformatf("member_id_out %h, want %h", got.member_id_out,
                         want.member_id_out));
      if (got.restore !== want.restore)
        report($sformatf("restore %0b, want %0b", got.restore, want.restore));
      if (got.used_size !== want.used_size)
        report($sformatf("used_size %0d, want %0d", got.used_size, want.used_size));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0, paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 0;
  logic        full;
  logic [1:0]  kind = 0;
  logic [4:0]  slot = 0;
  logic [23:0] entry_size = 0;
  logic [31:0] member_id = 0;
  logic        option_flag = 0;
  logic        empty;
  logic        pop = 0;
  logic [2:0]  result_kind;
  logic [4:0]  slot_res;
  logic [31:0] member_id_out;
  logic        restore;
  logic [31:0] used_size;
  logic        last;

  lru_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int wdog = 0;

  size_budget_lru_cache_policy_top dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full, .kind, .slot, .entry_size, .member_id, .option_flag,
    .empty, .pop, .result_kind, .slot_res, .member_id_out, .restore,
    .used_size, .last
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Monitor: commands are noted before results in the same edge; outputs are
  // read before the block's own updates land.
  always @(posedge clk) begin
    res_t got;
    if (!rst) begin
      if (push && !full) sb.note_command(kind_t'(kind), slot, entry_size, member_id,
                                         option_flag);
      if (pop && !empty) begin
        got.result_kind = res_kind_t'(result_kind);
        got.slot_res = slot_res;
        got.member_id_out = member_id_out;
        got.restore = restore;
        got.used_size = used_size;
        got.last = last;
        sb.check_result(got);
      end
      // Watchdog on cycles with no transaction on either side.
      if ((push && !full) || (pop && !empty)) wdog = 0;
      else wdog++;
      if (wdog >= WDOG_MAX) begin
        $display("timeout: no transaction for %0d cycles", WDOG_MAX);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Result side: random stalls set at the falling edge.
  always @(negedge clk)
    pop <= !rst && ($urandom_range(99) >= recv_stall_pct);

  task send_command(kind_t k, int s, logic [23:0] sz, logic [31:0] id, bit flag);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    push = 1;
    kind = k;
    slot = s[4:0];
    entry_size = sz;
    member_id = id;
    option_flag = flag;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = !full;
      @(negedge clk);
    end
    push = 0;
  endtask

  task wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Budget write and read back, only with the block idle.
  task write_limit(logic [31:0] val);
    wait_drained();
    repeat (60) @(negedge clk);
    psel = 1; pwrite = 1; paddr = 0; pwdata = val; penable = 0;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    sb.limit = val;
    psel = 0; penable = 0; pwrite = 0;
    @(negedge clk);
    psel = 1;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    if (prdata !== val) sb.report($sformatf("capacity_limit read %h, want %h", prdata, val));
    @(negedge clk);
    psel = 0; penable = 0;
  endtask

  function int pick_slot(bit want_valid);
    int q[$];
    for (int i = 0; i < NSLOT; i++) if (sb.valid[i] == want_valid) q.push_back(i);
    if (q.size() == 0 || $urandom_range(99) < 12) return $urandom_range(NSLOT - 1);
    return q[$urandom_range(q.size() - 1)];
  endfunction

  task random_command();
    int r;
    logic [23:0] sz;
    r = $urandom_range(99);
    sz = ($urandom_range(99) < 8) ? 24'($urandom) : 24'($urandom_range(400));
    if (r < 25)
      send_command(KIND_ADD, pick_slot(0), sz, $urandom, $urandom_range(99) < 15);
    else if (r < 35)
      send_command(KIND_REMOVE, pick_slot(1), 24'($urandom), $urandom, $urandom_range(1));
    else if (r < 92)
      send_command(KIND_ACCESS, pick_slot(1), 24'($urandom), $urandom, $urandom_range(1));
    else
      send_command(KIND_TRIM, $urandom_range(NSLOT - 1), 24'($urandom), $urandom,
                   $urandom_range(1));
  endtask

  initial begin
    logic [31:0] limits[6];
    int idles[4][2];
    limits = '{32'd1000, 32'd0, 32'd600, 32'hFFFF_FFFF, 32'd2500, LIMIT_RESET};
    idles = '{'{0, 0}, '{45, 0}, '{0, 45}, '{17, 17}};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: pinned and extreme entries, occupied and empty slots, hit,
    // miss with and without restore, evictions, no victim, trim.
    send_command(KIND_ADD, 0, 24'hFF_FFFF, 32'h0, 1);
    send_command(KIND_ADD, 31, 24'd100, 32'hFFFF_FFFF, 0);
    send_command(KIND_ADD, 31, 24'd5, 32'h1234_5678, 0);
    send_command(KIND_REMOVE, 5, 0, 0, 0);
    send_command(KIND_ACCESS, 5, 0, 0, 0);
    send_command(KIND_ACCESS, 31, 0, 0, 0);
    send_command(KIND_ACCESS, 31, 0, 0, 1);
    send_command(KIND_ACCESS, 0, 0, 0, 0);
    send_command(KIND_ADD, 2, 24'd0, 32'hA5A5_5A5A, 0);
    send_command(KIND_ACCESS, 2, 0, 0, 1);
    send_command(KIND_TRIM, 7, 0, 0, 0);
    write_limit(32'd150);
    send_command(KIND_ADD, 3, 24'd100, 32'h0000_0003, 0);
    send_command(KIND_ACCESS, 3, 0, 0, 0);
    send_command(KIND_ADD, 4, 24'hFF_FFFF, 32'h0000_0004, 0);
    send_command(KIND_ACCESS, 4, 0, 0, 0);
    send_command(KIND_REMOVE, 3, 0, 0, 0);
    send_command(KIND_REMOVE, 0, 0, 0, 0);
    send_command(KIND_ACCESS, 2, 0, 0, 0);
    write_limit(32'd0);
    send_command(KIND_TRIM, 0, 0, 0, 0);
    send_command(KIND_ACCESS, 31, 0, 0, 0);
    send_command(KIND_TRIM, 0, 0, 0, 1);

    // Random phases, each with its own budget and idling mix.
    for (int p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      send_idle_pct = idles[p % 4][0];
      recv_stall_pct = idles[p % 4][1];
      for (int n = 0; n < 80; n++) begin
        if (n == 40 && p == 2) wait_drained();  // let the queue run dry once
        random_command();
      end
    end

    wait_drained();
    repeat (1200) @(negedge clk);
    if (sb.pending.size() != 0) sb.report("expected results left over");
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
